// ----- rtl/tgf_pkg.sv -----
// Shared types, constants and helper functions of the Taylor-Green flow evaluator.
package tgf_pkg;

  localparam int DATA_W = 32;
  localparam int TRIG_W = 32;
  localparam int MAG_W  = 63;
  localparam int ANG_W  = 35;
  localparam int SAT_W  = 72;
  localparam int ATAN_N = 30;

  // 2*pi in Q60 and the angles derived from it
  localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;
  localparam logic signed [ANG_W-1:0] PI_Q30 =
    ANG_W'((TWO_PI_Q60 + (64'd1 << 30)) >> 31);
  localparam logic signed [ANG_W-1:0] HPI_Q30 =
    ANG_W'((TWO_PI_Q60 + (64'd1 << 31)) >> 32);
  localparam logic signed [ANG_W-1:0] GAIN_Q30 = 35'sd652032874;
  localparam logic signed [ANG_W-1:0] ONE_Q30  = 35'sd1073741824;

  // truncated atan(2^-i) in Q30
  localparam logic [31:0] ATAN_Q30 [ATAN_N] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
  };

  typedef enum logic [2:0] {
    CFG_AMP_X  = 3'd0,
    CFG_AMP_Y  = 3'd1,
    CFG_AMP_Z  = 3'd2,
    CFG_WAVE_X = 3'd3,
    CFG_WAVE_Y = 3'd4,
    CFG_WAVE_Z = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] pos_z;
  } pos_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_y;
    logic signed [DATA_W-1:0] vel_z;
    logic signed [DATA_W-1:0] vort_x;
    logic signed [DATA_W-1:0] vort_y;
    logic signed [DATA_W-1:0] vort_z;
    logic signed [DATA_W-1:0] def_xx;
    logic signed [DATA_W-1:0] def_yy;
    logic signed [DATA_W-1:0] def_zz;
    logic signed [DATA_W-1:0] def_xy;
    logic signed [DATA_W-1:0] def_xz;
    logic signed [DATA_W-1:0] def_yz;
  } flow_t;

  // 2*pi rounded to 2*frac fraction bits
  function automatic logic [63:0] mod_const(input int frac);
    int msh;
    msh = 60 - 2 * frac;
    return (TWO_PI_Q60 + (64'd1 << (msh - 1))) >> msh;
  endfunction

  // clamp a wide signed value to 32 bits
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    if (&v[SAT_W-1:DATA_W-1] || ~|v[SAT_W-1:DATA_W-1]) begin
      return v[DATA_W-1:0];
    end else if (v[SAT_W-1]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7FFF_FFFF;
    end
  endfunction

endpackage

// ----- rtl/tgf_stream_if.sv -----
// Valid/ready stream channel carrying one payload item per transfer.
interface tgf_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/tgf_red_cell.sv -----
// One conditional-subtract cell of the phase modulo reduction chain.
module tgf_red_cell import tgf_pkg::*; #(
  parameter logic [63:0] SUB = 64'd1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [MAG_W-1:0] mag_i,
  input  logic             neg_i,
  output logic [MAG_W-1:0] mag_o,
  output logic             neg_o
);

  logic [MAG_W-1:0] mag_q;
  logic             neg_q;
  logic [MAG_W:0]   diff;

  // borrow out means the multiple of the modulus does not fit
  assign diff = {1'b0, mag_i} - {1'b0, SUB[MAG_W-1:0]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= diff[MAG_W] ? mag_i : diff[MAG_W-1:0];
      neg_q <= neg_i;
    end
  end

  assign mag_o = mag_q;
  assign neg_o = neg_q;

endmodule

// ----- rtl/tgf_cordic_cell.sv -----
// One rotation-mode CORDIC micro-rotation cell.
module tgf_cordic_cell import tgf_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [ANG_W-1:0] x_i,
  input  logic signed [ANG_W-1:0] y_i,
  input  logic signed [ANG_W-1:0] z_i,
  input  logic                    neg_i,
  output logic signed [ANG_W-1:0] x_o,
  output logic signed [ANG_W-1:0] y_o,
  output logic signed [ANG_W-1:0] z_o,
  output logic                    neg_o
);

  logic signed [ANG_W-1:0] x_q, y_q, z_q;
  logic                    neg_q;
  logic signed [ANG_W-1:0] dx, dy, at;

  assign dx = y_i >>> IDX;
  assign dy = x_i >>> IDX;
  assign at = $signed({{(ANG_W-32){1'b0}}, ATAN_Q30[IDX]});

  // rotate towards zero residual angle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (z_i >= 0) begin
        x_q <= x_i - dx;
        y_q <= y_i + dy;
        z_q <= z_i - at;
      end else begin
        x_q <= x_i + dx;
        y_q <= y_i - dy;
        z_q <= z_i + at;
      end
      neg_q <= neg_i;
    end
  end

  assign x_o   = x_q;
  assign y_o   = y_q;
  assign z_o   = z_q;
  assign neg_o = neg_q;

endmodule

// ----- rtl/tgf_sincos.sv -----
// Per-axis lane: phase product, modulo 2*pi reduction, fold and CORDIC sine/cosine.
module tgf_sincos import tgf_pkg::*; #(
  parameter int CORDIC_STAGES = 16,
  parameter int FRAC_BITS     = 16
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [DATA_W-1:0] wave_i,
  input  logic signed [DATA_W-1:0] pos_i,
  output logic signed [TRIG_W-1:0] sin_o,
  output logic signed [TRIG_W-1:0] cos_o
);

  localparam logic [63:0] M   = mod_const(FRAC_BITS);
  localparam int          PH  = 2 * FRAC_BITS;
  localparam int          RED_N = 61 - 2 * FRAC_BITS;

  logic signed [63:0]      prod_q;
  logic [MAG_W-1:0]        red_mag [RED_N+1];
  logic                    red_neg [RED_N+1];
  logic [MAG_W-1:0]        res;
  logic [63:0]             ang64;
  logic signed [ANG_W-1:0] ang_q;
  logic signed [ANG_W-1:0] fold_a;
  logic                    fold_n;
  logic signed [ANG_W-1:0] cx [CORDIC_STAGES+1];
  logic signed [ANG_W-1:0] cy [CORDIC_STAGES+1];
  logic signed [ANG_W-1:0] cz [CORDIC_STAGES+1];
  logic                    cn [CORDIC_STAGES+1];
  logic signed [ANG_W-1:0] xc, yc;
  logic signed [TRIG_W-1:0] sin_q, cos_q;

  // exact phase product, then sign and magnitude
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q     <= wave_i * pos_i;
      red_neg[0] <= prod_q[63];
      red_mag[0] <= MAG_W'(prod_q[63] ? -prod_q : prod_q);
    end
  end

  // magnitude modulo M, one multiple of M per cell, largest first
  for (genvar k = 0; k < RED_N; k++) begin : g_red
    tgf_red_cell #(.SUB(M << (RED_N - 1 - k))) u_cell (
      .clk_i (clk_i),
      .en_i  (en_i),
      .mag_i (red_mag[k]),
      .neg_i (red_neg[k]),
      .mag_o (red_mag[k+1]),
      .neg_o (red_neg[k+1])
    );
  end

  // residue of a negative phase counts from M
  assign res = (red_neg[RED_N] && (red_mag[RED_N] != '0))
               ? M[MAG_W-1:0] - red_mag[RED_N] : red_mag[RED_N];

  // residue to Q30
  if (PH > 30) begin : g_down
    assign ang64 = ({1'b0, res} + (64'd1 << (PH - 31))) >> (PH - 30);
  end else if (PH == 30) begin : g_same
    assign ang64 = {1'b0, res};
  end else begin : g_up
    assign ang64 = {1'b0, res} << (30 - PH);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ang_q <= ANG_W'(ang64);
    end
  end

  // fold into [-pi/2, pi/2] with a sign flag
  always_comb begin
    fold_a = ang_q;
    fold_n = 1'b0;
    if (fold_a >= PI_Q30) begin
      fold_a = fold_a - PI_Q30;
      fold_n = 1'b1;
    end
    if (fold_a > HPI_Q30) begin
      fold_a = fold_a - PI_Q30;
      fold_n = !fold_n;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx[0] <= GAIN_Q30;
      cy[0] <= '0;
      cz[0] <= fold_a;
      cn[0] <= fold_n;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    tgf_cordic_cell #(.IDX(i)) u_cell (
      .clk_i (clk_i),
      .en_i  (en_i),
      .x_i   (cx[i]),
      .y_i   (cy[i]),
      .z_i   (cz[i]),
      .neg_i (cn[i]),
      .x_o   (cx[i+1]),
      .y_o   (cy[i+1]),
      .z_o   (cz[i+1]),
      .neg_o (cn[i+1])
    );
  end

  // clamp to unit magnitude and undo the fold
  always_comb begin
    xc = cx[CORDIC_STAGES];
    yc = cy[CORDIC_STAGES];
    if (xc > ONE_Q30)  xc = ONE_Q30;
    if (xc < -ONE_Q30) xc = -ONE_Q30;
    if (yc > ONE_Q30)  yc = ONE_Q30;
    if (yc < -ONE_Q30) yc = -ONE_Q30;
    if (cn[CORDIC_STAGES]) begin
      xc = -xc;
      yc = -yc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_q <= TRIG_W'(xc);
      sin_q <= TRIG_W'(yc);
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

// ----- rtl/taylor_green_flow_eval.sv -----
// Top level of the Taylor-Green vortex field evaluator.
//
// Usage: position items (pos_x, pos_y, pos_z, signed Q16.16) arrive on the
// pos_i stream; each gives one flow item (velocity, vorticity and the
// deformation-rate tensor, signed Q16.16, saturated) on the flow_o stream.
// Amplitudes and wave numbers are set through the cfg write port, index 0..5
// in the order amp_x, amp_y, amp_z, wave_x, wave_y, wave_z; writes to other
// indices are dropped. Write them only while no item is in flight.
// Stages from transfer in to the result showing on flow_o: phase product and
// magnitude (2), 61 - 2*FRAC_BITS modulo cells, Q30 conversion and fold (2),
// one cell per CORDIC stage, clamp (1) and five product and output stages.
// Throughput: one item per cycle while not stalled; all cells advance together.
// Reset clears the pipeline valid bits and loads amp_x = 1.0, amp_y = amp_z = 0,
// wave_x = wave_y = wave_z = 1.0. When the receiver stalls, the whole pipeline
// holds and pos_i.ready drops until the waiting result is transferred.
module taylor_green_flow_eval import tgf_pkg::*; #(
  parameter int CORDIC_STAGES = 16,
  parameter int FRAC_BITS     = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  tgf_stream_if.sink        pos_i,
  tgf_stream_if.source      flow_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [DATA_W-1:0] cfg_data_i
);

  localparam int LANE_LAT = 5 + (61 - 2 * FRAC_BITS) + CORDIC_STAGES;
  localparam int LAT      = LANE_LAT + 5;
  localparam int TW       = 66 - FRAC_BITS;
  localparam logic signed [DATA_W-1:0] ONE_FIX = DATA_W'(64'sd1 <<< FRAC_BITS);

  logic signed [DATA_W-1:0] amp_x_q, amp_y_q, amp_z_q;
  logic signed [DATA_W-1:0] wave_x_q, wave_y_q, wave_z_q;
  logic [LAT-1:0]           valid_q;
  logic                     adv;
  pos_t                     pos;
  logic signed [TRIG_W-1:0] sx, cx, sy, cy, sz, cz;
  logic signed [31:0]       cxsy_q, sxcy_q, sxsy_q, cxcy_q, sz_q, cz_q;
  logic signed [31:0]       t1_q, t2_q, t3_q, t4_q, t5_q, t6_q, t7_q;
  logic signed [32:0]       v1_q, v2_q, v3_q, v1d_q, v2d_q, v3d_q;
  logic signed [32:0]       u4a_q, u4b_q, u5a_q, u5b_q, u6a_q, u6b_q;
  logic signed [32:0]       u7x_q, u7y_q, u7z_q;
  logic signed [TW-1:0]     a4_q, b4_q, a5_q, b5_q, a6_q, b6_q, dx_q, dy_q, dz_q;
  logic signed [TW:0]       s4, s5, s6;
  flow_t                    flow_q;

  // round half up of a Q30 by Q30 product, result known to fit 32 bits
  function automatic logic signed [31:0] mr30(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b + 64'sd536870912;
    return p[61:30];
  endfunction

  // same rounding with one bit of headroom
  function automatic logic signed [32:0] mr30w(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b + 64'sd536870912;
    return p[62:30];
  endfunction

  // coefficient scaled term times amplitude, back to the field format
  function automatic logic signed [TW-1:0] term_r(input logic signed [32:0] u,
                                                  input logic signed [31:0] a);
    logic signed [65:0] p;
    p = u * a + (66'sd1 <<< (FRAC_BITS - 1));
    return p[65:FRAC_BITS];
  endfunction

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_x_q  <= ONE_FIX;
      amp_y_q  <= '0;
      amp_z_q  <= '0;
      wave_x_q <= ONE_FIX;
      wave_y_q <= ONE_FIX;
      wave_z_q <= ONE_FIX;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_AMP_X:  amp_x_q  <= cfg_data_i;
        CFG_AMP_Y:  amp_y_q  <= cfg_data_i;
        CFG_AMP_Z:  amp_z_q  <= cfg_data_i;
        CFG_WAVE_X: wave_x_q <= cfg_data_i;
        CFG_WAVE_Y: wave_y_q <= cfg_data_i;
        CFG_WAVE_Z: wave_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // whole pipeline advances unless a finished result is held
  assign adv         = !valid_q[LAT-1] || flow_o.ready;
  assign pos_i.ready = adv;
  assign pos         = pos_i.data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[LAT-2:0], pos_i.valid};
    end
  end

  // sine and cosine lanes
  tgf_sincos #(.CORDIC_STAGES(CORDIC_STAGES), .FRAC_BITS(FRAC_BITS)) u_lane_x (
    .clk_i (clk_i), .en_i (adv), .wave_i (wave_x_q), .pos_i (pos.pos_x),
    .sin_o (sx), .cos_o (cx)
  );
  tgf_sincos #(.CORDIC_STAGES(CORDIC_STAGES), .FRAC_BITS(FRAC_BITS)) u_lane_y (
    .clk_i (clk_i), .en_i (adv), .wave_i (wave_y_q), .pos_i (pos.pos_y),
    .sin_o (sy), .cos_o (cy)
  );
  tgf_sincos #(.CORDIC_STAGES(CORDIC_STAGES), .FRAC_BITS(FRAC_BITS)) u_lane_z (
    .clk_i (clk_i), .en_i (adv), .wave_i (wave_z_q), .pos_i (pos.pos_z),
    .sin_o (sz), .cos_o (cz)
  );

  // product stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      // pair products of x and y factors
      cxsy_q <= mr30(cx, sy);
      sxcy_q <= mr30(sx, cy);
      sxsy_q <= mr30(sx, sy);
      cxcy_q <= mr30(cx, cy);
      sz_q   <= sz;
      cz_q   <= cz;
      // triple products
      t1_q <= mr30(cxsy_q, sz_q);
      t2_q <= mr30(sxcy_q, sz_q);
      t3_q <= mr30(sxsy_q, cz_q);
      t4_q <= mr30(sxcy_q, cz_q);
      t5_q <= mr30(cxsy_q, cz_q);
      t6_q <= mr30(cxcy_q, sz_q);
      t7_q <= mr30(sxsy_q, sz_q);
      // velocity and wave number scaling
      v1_q  <= mr30w(t1_q, amp_x_q);
      v2_q  <= mr30w(t2_q, amp_y_q);
      v3_q  <= mr30w(t3_q, amp_z_q);
      u4a_q <= mr30w(t4_q, wave_y_q);
      u4b_q <= mr30w(t4_q, wave_z_q);
      u5a_q <= mr30w(t5_q, wave_z_q);
      u5b_q <= mr30w(t5_q, wave_x_q);
      u6a_q <= mr30w(t6_q, wave_x_q);
      u6b_q <= mr30w(t6_q, wave_y_q);
      u7x_q <= mr30w(t7_q, wave_x_q);
      u7y_q <= mr30w(t7_q, wave_y_q);
      u7z_q <= mr30w(t7_q, wave_z_q);
      // amplitude scaling of the gradient terms
      v1d_q <= v1_q;
      v2d_q <= v2_q;
      v3d_q <= v3_q;
      a4_q  <= term_r(u4a_q, amp_z_q);
      b4_q  <= term_r(u4b_q, amp_y_q);
      a5_q  <= term_r(u5a_q, amp_x_q);
      b5_q  <= term_r(u5b_q, amp_z_q);
      a6_q  <= term_r(u6a_q, amp_y_q);
      b6_q  <= term_r(u6b_q, amp_x_q);
      dx_q  <= term_r(u7x_q, amp_x_q);
      dy_q  <= term_r(u7y_q, amp_y_q);
      dz_q  <= term_r(u7z_q, amp_z_q);
    end
  end

  // symmetric parts, rounded half up
  assign s4 = (TW+1)'(a4_q) + (TW+1)'(b4_q) + (TW+1)'(1);
  assign s5 = (TW+1)'(a5_q) + (TW+1)'(b5_q) + (TW+1)'(1);
  assign s6 = (TW+1)'(a6_q) + (TW+1)'(b6_q) + (TW+1)'(1);

  // output register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      flow_q.vel_x  <= sat32(SAT_W'(v1d_q));
      flow_q.vel_y  <= sat32(SAT_W'(v2d_q));
      flow_q.vel_z  <= sat32(SAT_W'(v3d_q));
      flow_q.vort_x <= sat32(SAT_W'((TW+1)'(a4_q) - (TW+1)'(b4_q)));
      flow_q.vort_y <= sat32(SAT_W'((TW+1)'(a5_q) - (TW+1)'(b5_q)));
      flow_q.vort_z <= sat32(SAT_W'((TW+1)'(a6_q) - (TW+1)'(b6_q)));
      flow_q.def_xx <= sat32(SAT_W'(-(TW+1)'(dx_q)));
      flow_q.def_yy <= sat32(SAT_W'(-(TW+1)'(dy_q)));
      flow_q.def_zz <= sat32(SAT_W'(-(TW+1)'(dz_q)));
      flow_q.def_xy <= sat32(SAT_W'(s6 >>> 1));
      flow_q.def_xz <= sat32(SAT_W'(s5 >>> 1));
      flow_q.def_yz <= sat32(SAT_W'(s4 >>> 1));
    end
  end

  assign flow_o.valid = valid_q[LAT-1];
  assign flow_o.data  = flow_q;

  // x and z lane sine and cosine outputs stay within unit magnitude
  a_trig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[LANE_LAT-1] |->
      (sx >= -32'sd1073741824 && sx <= 32'sd1073741824 &&
       cx >= -32'sd1073741824 && cx <= 32'sd1073741824 &&
       sz >= -32'sd1073741824 && sz <= 32'sd1073741824 &&
       cz >= -32'sd1073741824 && cz <= 32'sd1073741824))
    else $error("lane sine/cosine out of range");

  // the cx*sy and sx*sy pair products of unit factors stay within unit magnitude
  a_pair_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[LANE_LAT] |->
      (cxsy_q >= -32'sd1073741824 && cxsy_q <= 32'sd1073741824 &&
       sxsy_q >= -32'sd1073741824 && sxsy_q <= 32'sd1073741824))
    else $error("pair product out of range");

  // a valid item at the lane outputs moves on into the product stages when the pipeline advances
  a_valid_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && valid_q[LANE_LAT-1]) |=> valid_q[LANE_LAT])
    else $error("item lost between lanes and product stages");

endmodule
